// ===== rtl/core/spfa_pkg.sv =====
// Shared types, constants and helpers of the SPH pressure-force accumulator.
`timescale 1ns / 1ps

package spfa_pkg;

   localparam int SPFA_FRAC_BITS = 16;
   localparam int SPFA_ACC_WIDTH = 48;

   // Configuration register indexes (byte address is 8 times the index).
   localparam logic [2:0] CSR_MASS   = 3'd0;
   localparam logic [2:0] CSR_GAS    = 3'd1;
   localparam logic [2:0] CSR_RADIUS = 3'd2;
   localparam logic [2:0] CSR_REST   = 3'd3;
   localparam logic [2:0] CSR_COEFF  = 3'd4;

   localparam logic [30:0] RST_MASS   = 31'd65536;
   localparam logic [30:0] RST_GAS    = 31'd3276800;
   localparam logic [30:0] RST_RADIUS = 31'd65536;
   localparam logic [30:0] RST_REST   = 31'd0;
   localparam logic [39:0] RST_COEFF  = 40'd938731;

   // Operations of the shared arithmetic unit.
   localparam logic [1:0] ALU_MUL  = 2'd0;
   localparam logic [1:0] ALU_DIV  = 2'd1;
   localparam logic [1:0] ALU_SQRT = 2'd2;

   // Result status codes; a larger code outranks a smaller one.
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SAT  = 2'd1;
   localparam logic [1:0] STATUS_ZDIV = 2'd2;

   localparam logic [63:0] SPFA_CAP63  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SPFA_TINY_K = 64'd1000000000000;

   localparam int MUL_DIGIT = 16;
   localparam int MUL_STEPS = 64 / MUL_DIGIT;

   typedef struct packed {
      logic [30:0] mass;
      logic [30:0] gas;
      logic [30:0] radius;
      logic [30:0] rest;
      logic [39:0] coeff;
   } cfg_type;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [63:0] opa;       // multiplicand or divisor
      logic [63:0] opb;       // multiplier, dividend or radicand
      logic [33:0] rem_init;  // starting partial remainder of a division
      logic [6:0]  iters;     // division or root iterations
   } alu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alu_sts_type;

   function automatic logic [1:0] raise_err(input logic [1:0] cur, input logic [1:0] code);
      raise_err = (code > cur) ? code : cur;
   endfunction

endpackage

// ===== rtl/core/spfa_csr.sv =====
// Configuration register file with an APB-style access port.
`timescale 1ns / 1ps

module spfa_csr import spfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [5:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign wr_en = psel & penable & pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[5:3])
            CSR_MASS:   cfg_in.mass   = pwdata[30:0];
            CSR_GAS:    cfg_in.gas    = pwdata[30:0];
            CSR_RADIUS: cfg_in.radius = pwdata[30:0];
            CSR_REST:   cfg_in.rest   = pwdata[30:0];
            CSR_COEFF:  cfg_in.coeff  = pwdata[39:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[5:3])
         CSR_MASS:   prdata = {33'd0, cfg_ff.mass};
         CSR_GAS:    prdata = {33'd0, cfg_ff.gas};
         CSR_RADIUS: prdata = {33'd0, cfg_ff.radius};
         CSR_REST:   prdata = {33'd0, cfg_ff.rest};
         CSR_COEFF:  prdata = {24'd0, cfg_ff.coeff};
         default:    prdata = 64'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mass   <= RST_MASS;
         cfg_ff.gas    <= RST_GAS;
         cfg_ff.radius <= RST_RADIUS;
         cfg_ff.rest   <= RST_REST;
         cfg_ff.coeff  <= RST_COEFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/spfa_alu.sv =====
// Shared iterative unit: 64x64 multiply by 16-bit digits, restoring divide, integer root.
`timescale 1ns / 1ps

module spfa_alu import spfa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  alu_cmd_type  cmd,
   output alu_sts_type  sts,
   output logic [127:0] prod,
   output logic [63:0]  quo
);

   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [1:0]   op_ff, op_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] acc_ff, acc_in;
   logic [63:0]  opa_ff, opa_in;
   logic [63:0]  shf_ff, shf_in;
   logic [63:0]  res_ff, res_in;
   logic [35:0]  rem_ff, rem_in;

   logic [MUL_DIGIT-1:0]    digit;
   logic [64+MUL_DIGIT-1:0] part;
   logic [35:0]             div_sh, sqrt_sh, sqrt_trial, div_dvs;

   assign digit      = shf_ff[63 -: MUL_DIGIT];
   assign part       = (64 + MUL_DIGIT)'(opa_ff) * (64 + MUL_DIGIT)'(digit);
   assign div_sh     = {rem_ff[34:0], shf_ff[63]};
   assign div_dvs    = {3'd0, opa_ff[32:0]};
   assign sqrt_sh    = {rem_ff[33:0], shf_ff[63:62]};
   assign sqrt_trial = {2'd0, res_ff[31:0], 2'b01};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      shf_in  = shf_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         opa_in  = cmd.opa;
         shf_in  = cmd.opb;
         acc_in  = '0;
         res_in  = '0;
         rem_in  = {2'd0, cmd.rem_init};
         cnt_in  = (cmd.op == ALU_MUL) ? 7'(MUL_STEPS) : cmd.iters;
      end else if (busy_ff) begin
         unique case (op_ff)
            ALU_MUL: begin
               acc_in = {acc_ff[127-MUL_DIGIT:0], {MUL_DIGIT{1'b0}}}
                        + 128'(part);
               shf_in = {shf_ff[63-MUL_DIGIT:0], {MUL_DIGIT{1'b0}}};
            end
            ALU_DIV: begin
               if (div_sh >= div_dvs) begin
                  rem_in = div_sh - div_dvs;
                  res_in = {res_ff[62:0], 1'b1};
               end else begin
                  rem_in = div_sh;
                  res_in = {res_ff[62:0], 1'b0};
               end
               shf_in = {shf_ff[62:0], 1'b0};
            end
            ALU_SQRT: begin
               if (sqrt_sh >= sqrt_trial) begin
                  rem_in = sqrt_sh - sqrt_trial;
                  res_in = {res_ff[62:0], 1'b1};
               end else begin
                  rem_in = sqrt_sh;
                  res_in = {res_ff[62:0], 1'b0};
               end
               shf_in = {shf_ff[61:0], 2'b00};
            end
            default: begin
               res_in = res_ff;
            end
         endcase
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= ALU_MUL;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      shf_ff <= shf_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign prod     = acc_ff;
   assign quo      = res_ff;

`ifndef SYNTHESIS
   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !cmd.start) else $error("unit started while busy");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(done_ff) |-> $past(busy_ff)) else $error("done without work");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("done while busy");
`endif

endmodule

// ===== rtl/core/sph_pressure_force_accumulator_top.sv =====
// Top level of the SPH spiky-kernel pressure-force accumulator.
`timescale 1ns / 1ps

// Each request carries one particle pair (both positions, both densities, a self flag in
// tuser and the last-neighbor mark in tlast); all values are Q16.16 by default. A pair that
// is in range adds the spiky-kernel pressure term to a three-component sum; on the last
// neighbor the sum divided by the particle's density leaves on the response channel with a
// status in tuser (0 ok, 1 saturated, 2 zero density met), and the sum is cleared. All
// arithmetic goes through one shared iterative unit (a 64x16 multiplier stepping through
// four digits, a one-bit-per-cycle restoring divider and a two-bit-per-cycle root), run by
// a sequencer, so the block takes one request at a time. A pair inside the kernel spends
// most of its time in the two 64-step divisions; a last neighbor adds up to three 33-step
// output divisions. A finished response sits in an output register, and the next request
// is accepted while it waits. Configuration is written over the csr_ port at byte address
// 8 times the register index; the user must write it only while the block is idle, and
// the block itself does not enforce this.
module sph_pressure_force_accumulator_top import spfa_pkg::*; #(
   parameter int FRAC_BITS = SPFA_FRAC_BITS,
   parameter int ACC_WIDTH = SPFA_ACC_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   // Request: self_x, self_y, self_z, other_x, other_y, other_z, self_density,
   // other_density, two zero pad bits (from the lowest bit up).
   input  logic [255:0] req_tdata,
   input  logic [0:0]   req_tuser,   // is_self
   input  logic         req_tlast,   // last_neighbor
   input  logic         req_tvalid,
   output logic         req_tready,
   // Response: accel_dx, accel_dy, accel_dz (from the lowest bit up).
   output logic [95:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,   // status
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready
);

   localparam int EMIT_SH = 33 - FRAC_BITS;

   localparam logic signed [65:0] ACC_HI = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
   localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ISSUE = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;
   localparam logic [2:0] S_ECHK  = 3'd5;
   localparam logic [2:0] S_EWAIT = 3'd6;
   localparam logic [2:0] S_PUSH  = 3'd7;

   // Steps of the pair computation.
   localparam logic [3:0] P_H2   = 4'd0;
   localparam logic [3:0] P_R0   = 4'd1;
   localparam logic [3:0] P_R1   = 4'd2;
   localparam logic [3:0] P_R2   = 4'd3;
   localparam logic [3:0] P_TINY = 4'd4;
   localparam logic [3:0] P_MK   = 4'd5;
   localparam logic [3:0] P_Q    = 4'd6;
   localparam logic [3:0] P_PRE  = 4'd7;
   localparam logic [3:0] P_SQRT = 4'd8;
   localparam logic [3:0] P_DD   = 4'd9;
   localparam logic [3:0] P_T    = 4'd10;
   localparam logic [3:0] P_G    = 4'd11;
   localparam logic [3:0] P_PG   = 4'd12;
   localparam logic [3:0] P_AX   = 4'd13;
   localparam logic [3:0] P_AY   = 4'd14;
   localparam logic [3:0] P_AZ   = 4'd15;

   cfg_type      cfg;
   alu_cmd_type  alu_cmd;
   alu_sts_type  alu_sts;
   logic [127:0] alu_prod;
   logic [63:0]  alu_quo;

   logic [2:0]  state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [1:0]  eidx_ff, eidx_in;
   logic [1:0]  err_ff, err_in;
   logic        esat_ff, esat_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [31:0] ad_ff [3];
   logic [31:0] ad_in [3];
   logic [2:0]  dneg_ff, dneg_in;
   logic [32:0] an_ff, an_in;
   logic        nneg_ff, nneg_in;
   logic [30:0] di_ff, di_in, dj_ff, dj_in;
   logic        self_ff, self_in, last_ff, last_in;

   logic [63:0] h2_ff, h2_in, r2_ff, r2_in, x0_ff, x0_in, x1_ff, x1_in;
   logic [31:0] root_ff, root_in;
   logic signed [ACC_WIDTH-1:0] sum_ff [3];
   logic signed [ACC_WIDTH-1:0] sum_in [3];
   logic [31:0] out_ff [3];
   logic [31:0] out_in [3];
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_stat_ff, rsp_stat_in;

   logic        accept, push_ok;
   logic [127:0] prod_sh;
   logic        mul_ovf;
   logic [63:0] mul_val, r2_sum, h_ext, dist_d;
   logic [1:0]  comp;
   logic signed [65:0] acc_wide, acc_delta;
   logic signed [64:0] emit_se;
   logic [63:0] emit_mag, emit_hi;
   logic        emit_neg, emit_ovf;
   logic [32:0] emit_q;
   logic [31:0] emit_val;
   logic        emit_vsat;

   spfa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   spfa_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .sts   (alu_sts),
      .prod  (alu_prod),
      .quo   (alu_quo)
   );

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign push_ok    = !rsp_valid_ff || rsp_tready;

   // Pair geometry and the symmetric pressure numerator, taken at accept.
   always_comb begin
      logic signed [32:0] d;
      logic signed [33:0] n;
      for (int c = 0; c < 3; c++) begin
         d = {req_tdata[32*c+31], req_tdata[32*c +: 32]}
             - {req_tdata[96+32*c+31], req_tdata[96+32*c +: 32]};
         dneg_in[c] = d[32];
         ad_in[c]   = d[32] ? 32'(-d) : d[31:0];
      end
      n = $signed({3'd0, req_tdata[222:192]}) + $signed({3'd0, req_tdata[253:223]})
          - $signed({2'd0, cfg.rest, 1'b0});
      nneg_in = n[33];
      an_in   = n[33] ? 33'(-n) : n[32:0];
      di_in   = req_tdata[222:192];
      dj_in   = req_tdata[253:223];
      self_in = req_tuser[0];
      last_in = req_tlast;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ad_ff   <= ad_in;
         dneg_ff <= dneg_in;
         an_ff   <= an_in;
         nneg_ff <= nneg_in;
         di_ff   <= di_in;
         dj_ff   <= dj_in;
         self_ff <= self_in;
         last_ff <= last_in;
      end
   end

   // Product scaling with clamp at 2^63-1.
   assign prod_sh = alu_prod >> FRAC_BITS;
   assign mul_ovf = |prod_sh[127:63];
   assign mul_val = mul_ovf ? SPFA_CAP63 : prod_sh[63:0];
   assign r2_sum  = r2_ff + alu_prod[63:0];
   assign h_ext   = {33'd0, cfg.radius};
   assign dist_d  = h_ext - {32'd0, root_ff};

   always_comb begin
      unique case (step_ff)
         P_AY:    comp = 2'd1;
         P_AZ:    comp = 2'd2;
         default: comp = 2'd0;
      endcase
   end

   assign acc_delta = (nneg_ff != dneg_ff[comp]) ? -$signed({2'd0, mul_val})
                                                 : $signed({2'd0, mul_val});
   assign acc_wide  = $signed({{(66-ACC_WIDTH){sum_ff[comp][ACC_WIDTH-1]}}, sum_ff[comp]})
                      + acc_delta;

   // Output division: quotient of (|sum| << FRAC_BITS) by the self density.
   assign emit_se   = $signed({{(65-ACC_WIDTH){sum_ff[eidx_ff][ACC_WIDTH-1]}},
                               sum_ff[eidx_ff]});
   assign emit_neg  = emit_se[64];
   assign emit_mag  = emit_neg ? 64'(-emit_se) : emit_se[63:0];
   assign emit_hi   = emit_mag >> EMIT_SH;
   assign emit_ovf  = emit_hi >= {33'd0, di_ff};
   assign emit_q    = alu_quo[32:0];

   always_comb begin
      emit_vsat = 1'b0;
      if (emit_neg) begin
         if (emit_q > 33'h0_8000_0000) begin
            emit_vsat = 1'b1;
            emit_val  = 32'h8000_0000;
         end else begin
            emit_val = 32'(-emit_q);
         end
      end else begin
         if (emit_q > 33'h0_7FFF_FFFF) begin
            emit_vsat = 1'b1;
            emit_val  = 32'h7FFF_FFFF;
         end else begin
            emit_val = emit_q[31:0];
         end
      end
   end

   // Command to the shared unit.
   always_comb begin
      alu_cmd          = '0;
      alu_cmd.iters    = 7'd64;
      if (state_ff == S_ISSUE) begin
         alu_cmd.start = 1'b1;
         unique case (step_ff)
            P_H2: begin
               alu_cmd.opa = h_ext;
               alu_cmd.opb = h_ext;
            end
            P_R0, P_R1, P_R2: begin
               alu_cmd.opa = {32'd0, ad_ff[step_ff[1:0] - 2'd1]};
               alu_cmd.opb = {32'd0, ad_ff[step_ff[1:0] - 2'd1]};
            end
            P_TINY: begin
               alu_cmd.opa = r2_ff;
               alu_cmd.opb = SPFA_TINY_K;
            end
            P_MK: begin
               alu_cmd.opa = {33'd0, cfg.mass};
               alu_cmd.opb = {33'd0, cfg.gas};
            end
            P_Q: begin
               alu_cmd.op  = ALU_DIV;
               alu_cmd.opa = {31'd0, dj_ff, 1'b0};
               alu_cmd.opb = {31'd0, an_ff} << FRAC_BITS;
            end
            P_PRE, P_PG: begin
               alu_cmd.opa = x0_ff;
               alu_cmd.opb = x1_ff;
            end
            P_SQRT: begin
               alu_cmd.op    = ALU_SQRT;
               alu_cmd.opb   = r2_ff;
               alu_cmd.iters = 7'd32;
            end
            P_DD: begin
               alu_cmd.opa = dist_d;
               alu_cmd.opb = dist_d;
            end
            P_T: begin
               alu_cmd.op  = ALU_DIV;
               alu_cmd.opa = {32'd0, root_ff};
               alu_cmd.opb = x1_ff;
            end
            P_G: begin
               alu_cmd.opa = {24'd0, cfg.coeff};
               alu_cmd.opb = x1_ff;
            end
            P_AX, P_AY, P_AZ: begin
               alu_cmd.opa = x0_ff;
               alu_cmd.opb = {32'd0, ad_ff[comp]};
            end
            default: begin
               alu_cmd.opa = x0_ff;
            end
         endcase
      end else if (state_ff == S_ECHK && di_ff != 31'd0 && !emit_ovf) begin
         alu_cmd.start    = 1'b1;
         alu_cmd.op       = ALU_DIV;
         alu_cmd.opa      = {33'd0, di_ff};
         alu_cmd.opb      = {33'((emit_mag << FRAC_BITS)), 31'd0};
         alu_cmd.rem_init = emit_hi[33:0];
         alu_cmd.iters    = 7'd33;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      eidx_in      = eidx_ff;
      err_in       = err_ff;
      esat_in      = esat_ff;
      h2_in        = h2_ff;
      r2_in        = r2_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      root_in      = root_ff;
      sum_in       = sum_ff;
      out_in       = out_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_stat_in  = rsp_stat_ff;
      rsp_valid_in = (rsp_valid_ff && rsp_tready) ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            priority if (self_ff) begin
               state_in = S_FIN;
            end else if (dj_ff == 31'd0) begin
               err_in   = raise_err(err_ff, STATUS_ZDIV);
               state_in = S_FIN;
            end else if (cfg.radius == 31'd0 || ad_ff[0] > h_ext[31:0]
                         || ad_ff[1] > h_ext[31:0] || ad_ff[2] > h_ext[31:0]) begin
               state_in = S_FIN;
            end else begin
               step_in  = P_H2;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (alu_sts.done) begin
               state_in = S_ISSUE;
               step_in  = step_ff + 4'd1;
               unique case (step_ff)
                  P_H2: h2_in = alu_prod[63:0];
                  P_R0: r2_in = alu_prod[63:0];
                  P_R1: r2_in = r2_sum;
                  P_R2: begin
                     r2_in = r2_sum;
                     if (r2_sum > h2_ff) begin
                        state_in = S_FIN;
                     end
                  end
                  P_TINY: begin
                     if (alu_prod < {64'd0, h2_ff}) begin
                        state_in = S_FIN;
                     end
                  end
                  P_Q, P_T: x1_in = alu_quo;
                  P_SQRT: root_in = alu_quo[31:0];
                  P_DD: x1_in = alu_prod[63:0];
                  P_MK, P_PRE, P_PG, P_G: begin
                     if (step_ff == P_G) begin
                        x1_in = mul_val;
                     end else begin
                        x0_in = mul_val;
                     end
                     if (mul_ovf) begin
                        err_in = raise_err(err_ff, STATUS_SAT);
                     end
                  end
                  P_AX, P_AY, P_AZ: begin
                     if (mul_ovf || acc_wide > ACC_HI || acc_wide < ACC_LO) begin
                        err_in = raise_err(err_ff, STATUS_SAT);
                     end
                     if (acc_wide > ACC_HI) begin
                        sum_in[comp] = ACC_HI[ACC_WIDTH-1:0];
                     end else if (acc_wide < ACC_LO) begin
                        sum_in[comp] = ACC_LO[ACC_WIDTH-1:0];
                     end else begin
                        sum_in[comp] = acc_wide[ACC_WIDTH-1:0];
                     end
                     if (step_ff == P_AZ) begin
                        state_in = S_FIN;
                     end
                  end
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_FIN: begin
            eidx_in = 2'd0;
            esat_in = 1'b0;
            state_in = last_ff ? S_ECHK : S_IDLE;
         end
         S_ECHK: begin
            priority if (di_ff == 31'd0) begin
               out_in[0] = '0;
               out_in[1] = '0;
               out_in[2] = '0;
               state_in  = S_PUSH;
            end else if (emit_ovf) begin
               esat_in         = 1'b1;
               out_in[eidx_ff] = emit_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
               eidx_in         = eidx_ff + 2'd1;
               state_in        = (eidx_ff == 2'd2) ? S_PUSH : S_ECHK;
            end else begin
               state_in = S_EWAIT;
            end
         end
         S_EWAIT: begin
            if (alu_sts.done) begin
               out_in[eidx_ff] = emit_val;
               esat_in         = esat_ff | emit_vsat;
               eidx_in         = eidx_ff + 2'd1;
               state_in        = (eidx_ff == 2'd2) ? S_PUSH : S_ECHK;
            end
         end
         S_PUSH: begin
            if (push_ok) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {out_ff[2], out_ff[1], out_ff[0]};
               priority if (di_ff == 31'd0) begin
                  rsp_stat_in = STATUS_ZDIV;
               end else if (esat_ff) begin
                  rsp_stat_in = raise_err(err_ff, STATUS_SAT);
               end else begin
                  rsp_stat_in = err_ff;
               end
               sum_in[0] = '0;
               sum_in[1] = '0;
               sum_in[2] = '0;
               err_in    = STATUS_OK;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= P_H2;
         eidx_ff      <= 2'd0;
         err_ff       <= STATUS_OK;
         esat_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff[0]    <= '0;
         sum_ff[1]    <= '0;
         sum_ff[2]    <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         eidx_ff      <= eidx_in;
         err_ff       <= err_in;
         esat_ff      <= esat_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      h2_ff       <= h2_in;
      r2_ff       <= r2_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      root_ff     <= root_in;
      out_ff      <= out_in;
      rsp_data_ff <= rsp_data_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

`ifndef SYNTHESIS
   a_idle_unit_free: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !alu_sts.busy) else $error("request taken while unit busy");
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_PUSH)) else $error("stray response");
   a_clear_after_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && push_ok) |=> (err_ff == STATUS_OK && sum_ff[0] == '0))
      else $error("sum not cleared after response");
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_stat_ff == STATUS_OK || rsp_stat_ff == STATUS_SAT
                        || rsp_stat_ff == STATUS_ZDIV)) else $error("bad status");
`endif

endmodule

// ===== dv/sph_pressure_force_accumulator_top_test.sv =====
// Self-checking testbench for the SPH spiky-kernel pressure-force accumulator.
`timescale 1ns / 1ps

module sph_pressure_force_accumulator_top_test;
   import spfa_pkg::*;

   typedef struct {
      logic signed [31:0] sx, sy, sz, ox, oy, oz;
      logic [30:0]        di, dj;
      logic               is_self, last;
   } pair_req_type;

   typedef struct {
      logic [31:0] dx, dy, dz;
      logic [1:0]  status;
   } accel_type;

   localparam int SETTLE_CYCLES = 400;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [255:0] req_tdata = '0;
   logic [0:0]   req_tuser = '0;
   logic         req_tlast = 1'b0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [95:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b1;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [5:0]   csr_paddr = '0;
   logic [63:0]  csr_pwdata = '0;
   logic [63:0]  csr_prdata;
   logic         csr_pready;

   sph_pressure_force_accumulator_top dut (.*);

   always #4 clock = ~clock;

   // Requests waiting to be driven, and the accelerations still owed by the block.
   pair_req_type pending_pairs[$];
   accel_type    accel_expected[$];
   int           error_count = 0;

   // The testbench's own copy of the configuration and of the accumulator.
   logic [63:0] mass_cfg, gas_cfg, radius_cfg, rest_cfg, coeff_cfg;
   longint      force_x, force_y, force_z;
   logic [1:0]  pending_err;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Q16.16 product of two magnitudes, clamped to 2^63-1 with a saturation flag.
   function automatic logic [63:0] q_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = ({64'd0, a} * {64'd0, b}) >> SPFA_FRAC_BITS;
      if (p[127:63] != 0) begin
         pending_err = raise_err(pending_err, STATUS_SAT);
         return SPFA_CAP63;
      end
      return p[63:0];
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 64'd0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic void add_force(ref longint s, input logic [63:0] mag, input bit neg);
      longint hi, lo, c;
      hi = (64'sd1 <<< (SPFA_ACC_WIDTH - 1)) - 1;
      lo = -hi - 1;
      c = neg ? -longint'(mag) : longint'(mag);
      if (c > 0 && s > hi - c) begin
         s = hi;
         pending_err = raise_err(pending_err, STATUS_SAT);
      end else if (c < 0 && s < lo - c) begin
         s = lo;
         pending_err = raise_err(pending_err, STATUS_SAT);
      end else begin
         s = s + c;
      end
   endfunction

   // Divides one sum by the particle density into a saturated Q16.16 value.
   function automatic logic [31:0] scale_by_density(input longint s, input logic [63:0] di,
                                                    inout bit sat);
      logic [63:0] mag, q, rem, val;
      mag = (s < 0) ? -s : s;
      q = mag / di;
      rem = mag % di;
      if (q >= (64'd1 << 32)) val = 64'd1 << 32;
      else val = (q << SPFA_FRAC_BITS) + (rem << SPFA_FRAC_BITS) / di;
      if (s < 0) begin
         if (val > 64'h8000_0000) begin
            val = 64'h8000_0000;
            sat = 1;
         end
         return -val[31:0];
      end
      if (val > 64'h7FFF_FFFF) begin
         val = 64'h7FFF_FFFF;
         sat = 1;
      end
      return val[31:0];
   endfunction

   // Folds one accepted pair into the accumulator and queues a result on the last neighbor.
   function automatic void accumulate_pair(input pair_req_type it);
      longint      d[3];
      logic [63:0] ad[3];
      logic [63:0] h, h2, r2, an, mk, q, pre, rr, dd, g, pg;
      longint      n;
      bit          far, sat;
      accel_type   res;
      if (!it.is_self) begin
         if (it.dj == 0) begin
            pending_err = raise_err(pending_err, STATUS_ZDIV);
         end else if (radius_cfg != 0) begin
            h = radius_cfg;
            h2 = h * h;
            d[0] = longint'(it.sx) - longint'(it.ox);
            d[1] = longint'(it.sy) - longint'(it.oy);
            d[2] = longint'(it.sz) - longint'(it.oz);
            far = 0;
            r2 = 0;
            for (int c = 0; c < 3; c++) begin
               ad[c] = (d[c] < 0) ? -d[c] : d[c];
               if (ad[c] > h) far = 1;
            end
            if (!far) begin
               for (int c = 0; c < 3; c++) r2 += ad[c] * ad[c];
               if (r2 <= h2 && r2 != 0 && r2 > (h2 - 1) / SPFA_TINY_K) begin
                  n = longint'(it.di) + longint'(it.dj) - 2 * longint'(rest_cfg);
                  an = (n < 0) ? -n : n;
                  mk = q_mul(mass_cfg, gas_cfg);
                  q = (an << SPFA_FRAC_BITS) / (2 * {33'd0, it.dj});
                  pre = q_mul(mk, q);
                  rr = int_sqrt(r2);
                  dd = h - rr;
                  g = q_mul(coeff_cfg, (dd * dd) / rr);
                  pg = q_mul(pre, g);
                  add_force(force_x, q_mul(pg, ad[0]), (n < 0) != (d[0] < 0));
                  add_force(force_y, q_mul(pg, ad[1]), (n < 0) != (d[1] < 0));
                  add_force(force_z, q_mul(pg, ad[2]), (n < 0) != (d[2] < 0));
               end
            end
         end
      end
      if (!it.last) return;
      res.status = pending_err;
      if (it.di == 0) begin
         res.dx = 0;
         res.dy = 0;
         res.dz = 0;
         res.status = STATUS_ZDIV;
      end else begin
         sat = 0;
         res.dx = scale_by_density(force_x, 64'(it.di), sat);
         res.dy = scale_by_density(force_y, 64'(it.di), sat);
         res.dz = scale_by_density(force_z, 64'(it.di), sat);
         if (sat) res.status = raise_err(res.status, STATUS_SAT);
      end
      accel_expected.push_back(res);
      force_x = 0;
      force_y = 0;
      force_z = 0;
      pending_err = STATUS_OK;
   endfunction

   // Monitor: requests and responses are taken at the rising edge.
   bit req_taken = 0;

   always @(posedge clock) begin
      accel_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            accumulate_pair(pending_pairs.pop_front());
            req_taken = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (accel_expected.size() == 0) begin
               report_mismatch("unexpected response", rsp_tdata[31:0], 32'd0);
            end else begin
               want = accel_expected.pop_front();
               if (rsp_tdata[31:0] !== want.dx) report_mismatch("accel_dx", rsp_tdata[31:0],
                                                               want.dx);
               if (rsp_tdata[63:32] !== want.dy) report_mismatch("accel_dy", rsp_tdata[63:32],
                                                                want.dy);
               if (rsp_tdata[95:64] !== want.dz) report_mismatch("accel_dz", rsp_tdata[95:64],
                                                                want.dz);
               if (rsp_tuser !== want.status) report_mismatch("status", 32'(rsp_tuser),
                                                              32'(want.status));
            end
         end
      end
   end

   // Driver: the sender works in bursts with random gaps; a request is held until taken.
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin
      if (!reset && !(req_tvalid && !req_taken)) begin
         req_taken = 0;
         if (gap_left > 0 || pending_pairs.size() == 0) begin
            if (gap_left > 0) gap_left--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, pending_pairs[0].dj, pending_pairs[0].di,
                          pending_pairs[0].oz, pending_pairs[0].oy, pending_pairs[0].ox,
                          pending_pairs[0].sz, pending_pairs[0].sy, pending_pairs[0].sx};
            req_tuser <= pending_pairs[0].is_self;
            req_tlast <= pending_pairs[0].last;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 10);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
            end
         end
      end
   end

   // The receiver stalls on its own pattern, picking a new style of stalling at random.
   int stall_mode = 0;
   int stall_tick = 0;

   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         1: rsp_tready <= (stall_tick % 7) < 3;
         2: rsp_tready <= 1'($urandom_range(0, 1));
         3: rsp_tready <= (stall_tick % 64) > 40;
         default: rsp_tready <= 1'b1;
      endcase
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         CSR_MASS:   mass_cfg = 64'(value[30:0]);
         CSR_GAS:    gas_cfg = 64'(value[30:0]);
         CSR_RADIUS: radius_cfg = 64'(value[30:0]);
         CSR_REST:   rest_cfg = 64'(value[30:0]);
         CSR_COEFF:  coeff_cfg = 64'(value[39:0]);
         default: ;
      endcase
   endtask

   task automatic add_pair(input logic [31:0] sx, sy, sz, ox, oy, oz,
                           input logic [30:0] di, dj, input bit is_self, last);
      pair_req_type it;
      it.sx = sx; it.sy = sy; it.sz = sz;
      it.ox = ox; it.oy = oy; it.oz = oz;
      it.di = di; it.dj = dj;
      it.is_self = is_self; it.last = last;
      pending_pairs.push_back(it);
   endtask

   function automatic logic [30:0] rand_density();
      case ($urandom_range(0, 9))
         0: return 31'($urandom());
         1: return 31'($urandom_range(0, 3));
         default: return 31'($urandom_range(32768, 20 * 65536));
      endcase
   endfunction

   // Mostly well-formed neighbor lists around one particle; the rest is noise.
   task automatic add_random_frames(input int count);
      longint reach, off[3];
      logic [31:0] base[3];
      logic [30:0] di;
      int len;
      reach = (radius_cfg > 64'h4000_0000) ? 64'h4000_0000 : radius_cfg;
      while (count > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            add_pair($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     31'($urandom()), 31'($urandom()), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
            count--;
         end else begin
            len = $urandom_range(1, 6);
            for (int c = 0; c < 3; c++) base[c] = $urandom();
            di = ($urandom_range(0, 30) == 0) ? 31'd0 : rand_density();
            for (int k = 0; k < len; k++) begin
               for (int c = 0; c < 3; c++)
                  off[c] = longint'($urandom_range(0, 2 * 1000)) * reach / 1000 - reach;
               add_pair(base[0], base[1], base[2], 32'(base[0] - off[0]),
                        32'(base[1] - off[1]), 32'(base[2] - off[2]), di,
                        ($urandom_range(0, 30) == 0) ? 31'd0 : rand_density(),
                        $urandom_range(0, 9) == 0, k == len - 1);
            end
            count -= len;
         end
      end
   endtask

   // Waits until every result has come, then lets an unfinished pair run out.
   task automatic drain();
      while (pending_pairs.size() != 0 || accel_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      mass_cfg = 64'(RST_MASS);
      gas_cfg = 64'(RST_GAS);
      radius_cfg = 64'(RST_RADIUS);
      rest_cfg = 64'(RST_REST);
      coeff_cfg = 64'(RST_COEFF);
      force_x = 0;
      force_y = 0;
      force_z = 0;
      pending_err = STATUS_OK;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed pairs under the reset configuration (radius 1.0).
      add_pair(0, 0, 0, 32'h4000, 0, 0, 31'h10000, 31'h10000, 0, 1);
      add_pair(0, 0, 0, 32'h10000, 0, 0, 31'h10000, 31'h20000, 0, 0);   // exactly at h
      add_pair(0, 0, 0, 1, 0, 0, 31'h10000, 31'h10000, 0, 0);           // smallest r
      add_pair(5, 5, 5, 5, 5, 5, 31'h10000, 31'h10000, 0, 1);           // zero distance
      add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1);      // far out
      add_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_C000, 32'h7FFF_F000,
               32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 1);
      add_pair(0, 0, 0, 32'hFFFF_C000, 32'h2000, 32'hFFFF_F000, 31'h1, 31'h1, 0, 1);
      add_pair(0, 0, 0, 0, 0, 0, 31'h10000, 31'h10000, 1, 1);           // self and last
      add_pair(0, 0, 0, 32'h100, 0, 0, 31'h10000, 31'h0, 0, 0);         // zero neighbor density
      add_pair(0, 0, 0, 32'h100, 32'h100, 0, 31'h10000, 31'h10000, 0, 1);
      add_pair(0, 0, 0, 32'h100, 0, 0, 31'h0, 31'h10000, 0, 1);         // zero self density
      add_pair(0, 0, 0, 32'h100, 0, 0, 31'h0, 31'h0, 1, 1);
      add_pair(32'h1234, 0, 0, 32'h1000, 32'h8000, 32'h8000, 31'h30000, 31'h18000, 0, 1);
      drain();

      add_random_frames(110);
      drain();

      // Largest radius and scaling: products and sums saturate.
      write_reg(CSR_MASS, 64'h7FFF_FFFF);
      write_reg(CSR_GAS, 64'h7FFF_FFFF);
      write_reg(CSR_RADIUS, 64'h7FFF_FFFF);
      write_reg(CSR_COEFF, 64'hFF_FFFF_FFFF);
      add_pair(0, 0, 0, 32'h1000_0000, 0, 0, 31'h10000, 31'h10000, 0, 1);
      add_pair(0, 0, 0, 32'h1, 0, 0, 31'h10000, 31'h10000, 0, 1);
      add_random_frames(100);
      drain();

      // Smallest radius, zero mass and gas, largest rest density.
      write_reg(CSR_RADIUS, 64'd1);
      write_reg(CSR_MASS, 64'd0);
      write_reg(CSR_GAS, 64'd0);
      write_reg(CSR_REST, 64'h7FFF_FFFF);
      write_reg(CSR_COEFF, 64'd0);
      add_pair(0, 0, 0, 1, 0, 0, 31'h10000, 31'h10000, 0, 1);
      add_random_frames(70);
      drain();

      // A rest density within the pairs' density range makes the pressure term negative for some pairs.
      write_reg(CSR_MASS, 64'h20000);
      write_reg(CSR_GAS, 64'h100000);
      write_reg(CSR_RADIUS, 64'h20000);
      write_reg(CSR_REST, 64'h80000);
      write_reg(CSR_COEFF, 64'h4000);
      add_random_frames(130);
      drain();

      // Random moderate settings per phase.
      for (int ph = 0; ph < 3; ph++) begin
         write_reg(CSR_MASS, 64'($urandom_range(1, 32'h40000)));
         write_reg(CSR_GAS, 64'($urandom_range(1, 32'h400000)));
         write_reg(CSR_RADIUS, 64'($urandom_range(1, 32'h100000)));
         write_reg(CSR_REST, 64'($urandom_range(0, 32'h100000)));
         write_reg(CSR_COEFF, {$urandom_range(0, 255), $urandom()});
         add_random_frames(80);
         drain();
      end

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
